/* sv/tsr_pkg.sv */
package tsr_pkg;

  // Default screen grid.
  localparam int unsigned X_CELLS_DEF = 120;
  localparam int unsigned Y_CELLS_DEF = 90;

  // Reciprocal divider widths. They cover every grid size from 16 to 127 cells.
  localparam int unsigned RECIP_W = 24;
  localparam int unsigned DIV_W   = 13;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned PROD_W  = RAW_W + RECIP_W;
  localparam int unsigned Q_W     = PROD_W - 32;
  localparam int unsigned QD_W    = RAW_W + 1;

  // Host command characters.
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_POLL = 8'h3F;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_STOP = 8'h2E;

  // Command numbers that select the report behavior.
  localparam logic [15:0] CMD_POLLED   = 16'd1;
  localparam logic [15:0] CMD_STREAM_A = 16'd129;
  localparam logic [15:0] CMD_STREAM_B = 16'd130;
  localparam logic [15:0] CMD_MAX      = 16'hFFFF;

  localparam logic [6:0] SCALE_MAX = 7'd127;
  localparam logic [7:0] BYTE_BASE = 8'h40;
  localparam logic [3:0] NIBBLE_UP = 4'hF;

  localparam int unsigned REPORT_NIBBLES = 4;
  localparam int unsigned REPORT_BYTES   = REPORT_NIBBLES + 1;
  localparam int unsigned BYTE_CNT_W     = $clog2(REPORT_BYTES);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Entry 0 is the first nibble sent.
  typedef logic [REPORT_NIBBLES-1:0][3:0] report_t;

  typedef struct packed {
    logic    valid;
    report_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* sv/tsr_if.sv */
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  host_byte;
  logic [15:0] position_x;
  logic [15:0] position_y;
  logic [2:0]  buttons;

  modport source (
    output valid, mode, host_byte, position_x, position_y, buttons,
    input  ready
  );
  modport sink (
    input  valid, mode, host_byte, position_x, position_y, buttons,
    output ready
  );
endinterface

interface tsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last;

  modport source (
    output valid, report_byte, last,
    input  ready
  );
  modport sink (
    input  valid, report_byte, last,
    output ready
  );
endinterface

/* sv/tsr_front.sv */
module tsr_front #(
  parameter int unsigned X_CELLS = tsr_pkg::X_CELLS_DEF,
  parameter int unsigned Y_CELLS = tsr_pkg::Y_CELLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tsr_in_if.sink                 in_i,
  output tsr_pkg::push_t         push_o,
  input  tsr_pkg::queue_status_t status_i
);
  import tsr_pkg::*;

  localparam int unsigned DivX = 65536 / X_CELLS;
  localparam int unsigned DivY = 65536 / Y_CELLS;
  localparam longint unsigned RecipX = 64'd4294967296 / DivX;
  localparam longint unsigned RecipY = 64'd4294967296 / DivY;
  localparam logic [RECIP_W-1:0] RECIP_X_C = RECIP_W'(RecipX);
  localparam logic [RECIP_W-1:0] RECIP_Y_C = RECIP_W'(RecipY);
  localparam logic [DIV_W-1:0]   DIV_X_C   = DIV_W'(DivX);
  localparam logic [DIV_W-1:0]   DIV_Y_C   = DIV_W'(DivY);

  // The reciprocal estimate is at most one low; one compare fixes it.
  function automatic logic [6:0] scale_fix(logic [RAW_W-1:0] raw, logic [Q_W-1:0] q,
                                           logic [QD_W-1:0] qd, logic [DIV_W-1:0] div);
    logic [QD_W-1:0] rem;
    logic [Q_W:0]    v;
    rem = {1'b0, raw} - qd;
    v   = {1'b0, q} + (Q_W+1)'(1) + ((rem >= QD_W'(div)) ? (Q_W+1)'(1) : (Q_W+1)'(0));
    return (v > (Q_W+1)'(SCALE_MAX)) ? SCALE_MAX : v[6:0];
  endfunction

  // Stage 1: reciprocal products.
  logic                v1_q;
  logic                mode1_q;
  logic [7:0]          byte1_q;
  logic [2:0]          btn1_q;
  logic [RAW_W-1:0]    rawx1_q, rawy1_q;
  logic [PROD_W-1:0]   prodx1_q, prody1_q;
  // Stage 2: quotient estimates and their back products.
  logic                v2_q;
  logic                mode2_q;
  logic [7:0]          byte2_q;
  logic [2:0]          btn2_q;
  logic [RAW_W-1:0]    rawx2_q, rawy2_q;
  logic [Q_W-1:0]      qx2_q, qy2_q;
  logic [QD_W-1:0]     qdx2_q, qdy2_q;
  // Stage 3: scaled position, classified against the command state.
  logic                v3_q;
  logic                mode3_q;
  logic [7:0]          byte3_q;
  logic [2:0]          btn3_q;
  logic [6:0]          x3_q, y3_q;

  logic                ready1, ready2, ready3;
  logic [RAW_W-1:0]    raw_x_inv;
  logic [PROD_W-1:0]   prodx, prody;
  logic [Q_W-1:0]      qx_est, qy_est;
  logic [Q_W+DIV_W-1:0] qdx_full, qdy_full;

  // Command and history state.
  logic [15:0] cmd_q, cmd_d;
  logic [6:0]  prev_x_q, prev_y_q;
  logic [2:0]  prev_btn_q;
  logic        prev_valid_q;
  logic        report;
  logic        consume;
  logic [7:0]  digit_sub;
  logic [19:0] cmd_ext;
  report_t     data;

  assign ready3     = !v3_q || !status_i.full;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_i.ready = ready1;
  assign consume    = v3_q && !status_i.full;

  assign raw_x_inv = ~in_i.position_x;
  assign prodx     = PROD_W'(raw_x_inv) * PROD_W'(RECIP_X_C);
  assign prody     = PROD_W'(in_i.position_y) * PROD_W'(RECIP_Y_C);
  assign qx_est    = prodx1_q[PROD_W-1:32];
  assign qy_est    = prody1_q[PROD_W-1:32];
  assign qdx_full  = (Q_W+DIV_W)'(qx_est) * (Q_W+DIV_W)'(DIV_X_C);
  assign qdy_full  = (Q_W+DIV_W)'(qy_est) * (Q_W+DIV_W)'(DIV_Y_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_i.valid;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      mode1_q  <= in_i.mode;
      byte1_q  <= in_i.host_byte;
      btn1_q   <= in_i.buttons;
      rawx1_q  <= raw_x_inv;
      rawy1_q  <= in_i.position_y;
      prodx1_q <= prodx;
      prody1_q <= prody;
    end
    if (ready2) begin
      mode2_q <= mode1_q;
      byte2_q <= byte1_q;
      btn2_q  <= btn1_q;
      rawx2_q <= rawx1_q;
      rawy2_q <= rawy1_q;
      qx2_q   <= qx_est;
      qy2_q   <= qy_est;
      qdx2_q  <= qdx_full[QD_W-1:0];
      qdy2_q  <= qdy_full[QD_W-1:0];
    end
    if (ready3) begin
      mode3_q <= mode2_q;
      byte3_q <= byte2_q;
      btn3_q  <= btn2_q;
      x3_q    <= scale_fix(rawx2_q, qx2_q, qdx2_q, DIV_X_C);
      y3_q    <= scale_fix(rawy2_q, qy2_q, qdy2_q, DIV_Y_C);
    end
  end

  assign digit_sub = byte3_q - CHAR_ZERO;
  assign cmd_ext   = 20'({cmd_q, 3'b000}) + 20'({cmd_q, 1'b0}) + 20'(digit_sub[3:0]);

  always_comb begin
    logic poll;
    logic stream;
    logic changed;
    poll  = 1'b0;
    cmd_d = cmd_q;
    if (mode3_q) begin
      if (byte3_q == CHAR_M) begin
        cmd_d = '0;
      end else if (byte3_q >= CHAR_ZERO && byte3_q <= CHAR_NINE) begin
        cmd_d = (cmd_ext > 20'(CMD_MAX)) ? CMD_MAX : cmd_ext[15:0];
      end else if (byte3_q == CHAR_POLL) begin
        poll = (cmd_q == CMD_POLLED);
      end
    end
    stream  = (cmd_d == CMD_STREAM_A) || (cmd_d == CMD_STREAM_B);
    changed = !prev_valid_q || (x3_q != prev_x_q) || (y3_q != prev_y_q) ||
              (btn3_q != prev_btn_q);
    report  = poll || (stream && changed);
  end

  always_comb begin
    if (btn3_q[0]) begin
      data[0] = {1'b0, x3_q[6:4]};
      data[1] = x3_q[3:0];
      data[2] = {1'b0, y3_q[6:4]};
      data[3] = y3_q[3:0];
    end else begin
      data = {REPORT_NIBBLES{NIBBLE_UP}};
    end
  end

  assign push_o.valid = consume && report;
  assign push_o.data  = data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_btn_q   <= '0;
      prev_valid_q <= 1'b0;
    end else if (consume) begin
      cmd_q <= cmd_d;
      if (report) begin
        prev_x_q     <= x3_q;
        prev_y_q     <= y3_q;
        prev_btn_q   <= btn3_q;
        prev_valid_q <= 1'b1;
      end
    end
  end

endmodule

/* sv/tsr_queue.sv */
module tsr_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsr_pkg::push_t         push_i,
  input  logic                   pop_i,
  output tsr_pkg::queue_status_t status_o,
  output tsr_pkg::report_t       head_o
);
  import tsr_pkg::*;

  report_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i.valid && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.data;
  end

endmodule

/* sv/tsr_back.sv */
module tsr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsr_pkg::queue_status_t status_i,
  input  tsr_pkg::report_t       head_i,
  output logic                   pop_o,
  tsr_out_if.source              out_o
);
  import tsr_pkg::*;

  localparam logic [BYTE_CNT_W-1:0] LAST_IDX = BYTE_CNT_W'(REPORT_BYTES - 1);

  logic                  busy_q;
  logic [BYTE_CNT_W-1:0] cnt_q;
  report_t               data_q;
  logic                  out_done;
  logic                  is_last;

  assign is_last  = (cnt_q == LAST_IDX);
  assign out_done = out_o.valid && out_o.ready;
  // The next report loads as the terminator of the current one goes out.
  assign pop_o    = !status_i.empty && (!busy_q || (out_done && is_last));

  assign out_o.valid       = busy_q;
  assign out_o.last        = is_last;
  assign out_o.report_byte = is_last ? CHAR_STOP
                                     : BYTE_BASE + {4'b0000, data_q[cnt_q[1:0]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (out_done) begin
      if (is_last) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + BYTE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i;
  end

endmodule

/* sv/touch_screen_serial_reporter_core.sv */
// A reporting item passes through the pipeline stages and the report queue to the serializer.
// The front takes one item per cycle unless a full queue stalls it; a report holds the output
// for its five bytes, and a four-report queue absorbs bursts before input stalls.
// Reset clears the command number, the last reported position and buttons, the pipeline,
// the queue and the serializer; the first streaming item after reset always reports.
module touch_screen_serial_reporter_core #(
  parameter int unsigned X_CELLS = tsr_pkg::X_CELLS_DEF,
  parameter int unsigned Y_CELLS = tsr_pkg::Y_CELLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsr_in_if.sink    in_i,
  tsr_out_if.source out_o
);
  import tsr_pkg::*;

  push_t         push;
  queue_status_t status;
  report_t       head;
  logic          pop;

  tsr_front #(
    .X_CELLS(X_CELLS),
    .Y_CELLS(Y_CELLS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .status_i(status)
  );

  tsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .status_o(status),
    .head_o  (head)
  );

  tsr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* tb/sv/touch_screen_serial_reporter_core_test.sv */
`timescale 1ns / 1ps

module touch_screen_serial_reporter_core_test;
  import tsr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES  = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } report_byte_t;

  logic clk_i;
  logic rst_ni;

  tsr_in_if  in_bus ();
  tsr_out_if out_bus ();

  touch_screen_serial_reporter_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Predicted controller state.
  logic [15:0] cmd_number;
  logic [6:0]  sent_x;
  logic [6:0]  sent_y;
  logic [2:0]  sent_buttons;
  logic        sent_valid;

  report_byte_t pending_bytes[$];
  int unsigned  error_count;
  int unsigned  items_sent;
  int unsigned  quiet_cycles;
  bit           tx_gaps;
  bit           rx_gaps;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [6:0] scale_cell(input logic [15:0] raw, input int unsigned cells);
    int unsigned step;
    int unsigned scaled;
    step   = 65536 / cells;
    scaled = raw / step + 1;
    if (scaled > SCALE_MAX) begin
      scaled = SCALE_MAX;
    end
    return scaled[6:0];
  endfunction

  function automatic void queue_report(input logic [6:0] x, input logic [6:0] y,
                                       input logic [2:0] btn);
    logic [3:0] nib [4];
    report_byte_t entry;
    if (btn[0]) begin
      nib[0] = {1'b0, x[6:4]};
      nib[1] = x[3:0];
      nib[2] = {1'b0, y[6:4]};
      nib[3] = y[3:0];
    end else begin
      for (int k = 0; k < 4; k++) begin
        nib[k] = NIBBLE_UP;
      end
    end
    for (int k = 0; k < 4; k++) begin
      entry.data = BYTE_BASE + nib[k];
      entry.last = 1'b0;
      pending_bytes.push_back(entry);
    end
    entry.data = CHAR_STOP;
    entry.last = 1'b1;
    pending_bytes.push_back(entry);
    sent_x       = x;
    sent_y       = y;
    sent_buttons = btn;
    sent_valid   = 1'b1;
  endfunction

  // The command byte is handled first; a streaming number then checks for a change.
  function automatic void track_sample(input bit mode, input logic [7:0] b,
                                       input logic [15:0] px, input logic [15:0] py,
                                       input logic [2:0] btn);
    logic [6:0] cx;
    logic [6:0] cy;
    int unsigned next_num;
    cx = scale_cell(16'hFFFF - px, X_CELLS_DEF);
    cy = scale_cell(py, Y_CELLS_DEF);
    if (mode) begin
      if (b == CHAR_M) begin
        cmd_number = '0;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        next_num   = cmd_number * 10 + (b - CHAR_ZERO);
        cmd_number = (next_num > CMD_MAX) ? CMD_MAX : next_num[15:0];
      end else if (b == CHAR_POLL && cmd_number == CMD_POLLED) begin
        queue_report(cx, cy, btn);
        return;
      end
    end
    if ((cmd_number == CMD_STREAM_A || cmd_number == CMD_STREAM_B) &&
        (!sent_valid || cx != sent_x || cy != sent_y || btn != sent_buttons)) begin
      queue_report(cx, cy, btn);
    end
  endfunction

  task automatic send_item(input bit mode, input logic [7:0] b, input logic [15:0] px,
                           input logic [15:0] py, input logic [2:0] btn);
    @(negedge clk_i);
    while (tx_gaps && $urandom_range(99) < 35) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= mode;
    in_bus.host_byte  <= b;
    in_bus.position_x <= px;
    in_bus.position_y <= py;
    in_bus.buttons    <= btn;
    @(posedge clk_i);
    while (!in_bus.ready) begin
      @(posedge clk_i);
    end
    track_sample(mode, b, px, py, btn);
    items_sent++;
  endtask

  // Holds the input off until every predicted byte has come out.
  task automatic drain_reports();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic enter_number(input int unsigned num, input logic [15:0] px,
                              input logic [15:0] py, input logic [2:0] btn);
    int unsigned digits[$];
    int unsigned rest;
    rest = num;
    do begin
      digits.push_front(rest % 10);
      rest = rest / 10;
    end while (rest != 0);
    send_item(1'b1, CHAR_M, px, py, btn);
    foreach (digits[k]) begin
      send_item(1'b1, 8'(CHAR_ZERO + digits[k]), px, py, btn);
    end
  endtask

  task automatic wander(inout logic [15:0] px, inout logic [15:0] py, inout logic [2:0] btn);
    case ($urandom_range(5))
      0, 1: ;
      2: begin
        px = px + 16'($urandom_range(600)) - 16'd300;
        py = py + 16'($urandom_range(800)) - 16'd400;
      end
      3: begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      default: btn = 3'($urandom);
    endcase
  endtask

  task automatic test_first_stream_report();
    // The number reaches 129 on the last digit, and nothing has been reported yet.
    enter_number(129, 16'd30000, 16'd30000, 3'b001);
    send_item(1'b0, 8'h00, 16'd30000, 16'd30000, 3'b001);
    send_item(1'b0, 8'hFF, 16'd30000, 16'd30000, 3'b011);
    send_item(1'b0, 8'h00, 16'd30010, 16'd30000, 3'b011);
    send_item(1'b1, CHAR_STOP, 16'd30010, 16'd30000, 3'b011);
    drain_reports();
  endtask

  task automatic test_polled_reports();
    enter_number(1, 16'd0, 16'd0, 3'b000);
    send_item(1'b1, CHAR_POLL, 16'h0000, 16'hFFFF, 3'b001);
    send_item(1'b1, CHAR_POLL, 16'hFFFF, 16'h0000, 3'b000);
    send_item(1'b1, CHAR_POLL, 16'hFFFF, 16'h0000, 3'b111);
    send_item(1'b1, 8'h5A, 16'h1234, 16'h5678, 3'b110);
    send_item(1'b0, CHAR_POLL, 16'h1234, 16'h5678, 3'b110);
    drain_reports();
  endtask

  task automatic test_command_number_limits();
    send_item(1'b1, CHAR_M, 16'h8000, 16'h8000, 3'b101);
    repeat (5) begin
      send_item(1'b1, CHAR_NINE, 16'h8000, 16'h8000, 3'b101);
    end
    send_item(1'b1, CHAR_ZERO + 8'd7, 16'h8000, 16'h8000, 3'b101);
    send_item(1'b1, CHAR_POLL, 16'h8000, 16'h8000, 3'b101);
    // The final digit of 130 reports on its own item.
    enter_number(130, 16'h4000, 16'hC000, 3'b001);
    send_item(1'b0, 8'h00, 16'h4000, 16'hC000, 3'b001);
    drain_reports();
  endtask

  task automatic test_random_sessions();
    int unsigned first;
    int unsigned runs;
    int unsigned pick;
    logic [15:0] px;
    logic [15:0] py;
    logic [2:0]  btn;
    first = items_sent;
    px    = 16'($urandom);
    py    = 16'($urandom);
    btn   = 3'($urandom);
    while (items_sent - first < RANDOM_ITEMS) begin
      // One long stretch runs with both sides streaming back to back.
      tx_gaps = !(items_sent - first >= 150 && items_sent - first < 250);
      rx_gaps = tx_gaps;
      if ($urandom_range(9) == 0) begin
        drain_reports();
      end
      pick = $urandom_range(99);
      runs = $urandom_range(3, 12);
      if (pick < 30) begin
        enter_number(CMD_POLLED, px, py, btn);
        repeat (runs) begin
          wander(px, py, btn);
          if ($urandom_range(2) != 0) begin
            send_item(1'b1, CHAR_POLL, px, py, btn);
          end else begin
            send_item(1'($urandom_range(1)), 8'($urandom), px, py, btn);
          end
        end
      end else if (pick < 70) begin
        enter_number($urandom_range(1) ? CMD_STREAM_A : CMD_STREAM_B, px, py, btn);
        repeat (runs) begin
          wander(px, py, btn);
          if ($urandom_range(4) == 0) begin
            send_item(1'b1, 8'($urandom), px, py, btn);
          end else begin
            send_item(1'b0, 8'($urandom), px, py, btn);
          end
        end
      end else if (pick < 85) begin
        send_item(1'b1, CHAR_M, px, py, btn);
        repeat ($urandom_range(1, 6)) begin
          send_item(1'b1, 8'(CHAR_ZERO + $urandom_range(9)), px, py, btn);
        end
        repeat (runs) begin
          wander(px, py, btn);
          send_item(1'($urandom_range(1)), $urandom_range(1) ? CHAR_POLL : 8'($urandom), px,
                    py, btn);
        end
      end else begin
        repeat (runs) begin
          send_item(1'($urandom_range(1)), 8'($urandom), 16'($urandom), 16'($urandom),
                    3'($urandom));
        end
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  always @(negedge clk_i) begin
    out_bus.ready <= !rx_gaps || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    report_byte_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected report byte %h last %b", $time, out_bus.report_byte,
                   out_bus.last);
          error_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_bus.report_byte !== want.data) begin
            $display("%0t: report byte mismatch: expected %h, actual %h", $time, want.data,
                     out_bus.report_byte);
            error_count++;
          end
          if (out_bus.last !== want.last) begin
            $display("%0t: last flag mismatch: expected %b, actual %b", $time, want.last,
                     out_bus.last);
            error_count++;
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("FAIL touch_screen_serial_reporter_core");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.mode       = 1'b0;
    in_bus.host_byte  = '0;
    in_bus.position_x = '0;
    in_bus.position_y = '0;
    in_bus.buttons    = '0;
    out_bus.ready     = 1'b0;
    cmd_number        = '0;
    sent_x            = '0;
    sent_y            = '0;
    sent_buttons      = '0;
    sent_valid        = 1'b0;
    error_count       = 0;
    items_sent        = 0;
    quiet_cycles      = 0;
    tx_gaps           = 1'b1;
    rx_gaps           = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_stream_report();
    test_polled_reports();
    test_command_number_limits();
    test_random_sessions();

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d report bytes never arrived", $time, pending_bytes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS touch_screen_serial_reporter_core");
    end else begin
      $display("FAIL touch_screen_serial_reporter_core");
    end
    $finish;
  end

endmodule
